>>> design/bva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bva_pkg
// Types and constants shared by the bricked volume voxel address block.
// ----------------------------------------------------------------------------
package bva_pkg;

  localparam int unsigned IDX_W      = 12;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned MORTON_IN_W = 8;

  typedef enum logic [1:0] {
    MODE_LOOKUP     = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_READ_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRICK_SHIFT    = 2'd0,
    CFG_BRICKS_ALONG_X = 2'd1,
    CFG_BRICKS_ALONG_Y = 2'd2,
    CFG_FALLBACK_LEVEL = 2'd3
  } cfg_idx_e;

  // one brick table entry
  typedef struct packed {
    logic               used;
    logic               loaded;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  // interleave x at bit 0, y at bit 1, z at bit 2
  function automatic logic [OFF_W-1:0] morton3(input logic [MORTON_IN_W-1:0] a,
                                                input logic [MORTON_IN_W-1:0] b,
                                                input logic [MORTON_IN_W-1:0] c);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = 0; i < MORTON_IN_W; i++) begin
      r[3*i]     = a[i];
      r[3*i + 1] = b[i];
      r[3*i + 2] = c[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/bva_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bva_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bva_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> design/bricked_volume_voxel_address.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bricked_volume_voxel_address
// Voxel coordinate to brick index and in-brick Morton offset, with a brick
// table of loaded, level and used marks.
// ----------------------------------------------------------------------------
// Each transaction passes through these steps from acceptance to its result in
// the output register: shifting the coordinates and forming the y term and the
// product of the brick counts, multiplying in the z term and forming the linear
// index, issuing the brick table read, and a read-modify-write of the table
// entry that builds the result. The block handles one transaction at a time and
// returns to idle after each; a new item is taken while the previous result
// still waits in the output register, and the last step holds while that
// register is full and not being read. The brick table is a single synchronous
// RAM of MAX_BRICKS entries; after reset a clearing pass writes zero to every
// entry, during which no item is accepted (configuration writes are always
// taken).
module bricked_volume_voxel_address #(
  parameter int unsigned MAX_BRICKS = 4096,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bva_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bva_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         mode_i,
  input  wire logic [COORD_BITS-1:0]              x_coord_i,
  input  wire logic [COORD_BITS-1:0]              y_coord_i,
  input  wire logic [COORD_BITS-1:0]              z_coord_i,
  input  wire logic [bva_pkg::IDX_W-1:0]          entry_index_i,
  input  wire logic                               entry_loaded_i,
  input  wire logic [bva_pkg::LEVEL_W-1:0]        entry_level_i,
  // results
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [bva_pkg::IDX_W-1:0]               brick_index_o,
  output logic [bva_pkg::OFF_W-1:0]               voxel_offset_o,
  output logic [bva_pkg::LEVEL_W-1:0]             level_o,
  output logic                                    from_fallback_o,
  output logic                                    out_of_range_o,
  output logic                                    used_before_o
);

  localparam int unsigned AW    = (MAX_BRICKS > 1) ? $clog2(MAX_BRICKS) : 1;
  localparam int unsigned CW    = bva_pkg::COUNT_W;
  localparam int unsigned PROD_W = COORD_BITS + 2 * CW;
  localparam int unsigned LIN_W = PROD_W + 1;
  localparam int unsigned EW    = $bits(bva_pkg::entry_t);
  localparam logic [LIN_W-1:0] MaxLin = LIN_W'(MAX_BRICKS);
  localparam logic [16:0]      MaxEi  = 17'(MAX_BRICKS);
  localparam logic [AW-1:0]    LastAddr = AW'(MAX_BRICKS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_ADDR  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [bva_pkg::SHIFT_W-1:0] brick_shift_q;
  logic [CW-1:0]               nx_q, ny_q;
  logic [bva_pkg::LEVEL_W-1:0] fallback_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brick_shift_q <= bva_pkg::SHIFT_W'(6);
      nx_q          <= CW'(16);
      ny_q          <= CW'(16);
      fallback_q    <= bva_pkg::LEVEL_W'(3);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bva_pkg::CFG_BRICK_SHIFT:    brick_shift_q <= cfg_data_i[bva_pkg::SHIFT_W-1:0];
        bva_pkg::CFG_BRICKS_ALONG_X: nx_q <= cfg_data_i[CW-1:0];
        bva_pkg::CFG_BRICKS_ALONG_Y: ny_q <= cfg_data_i[CW-1:0];
        bva_pkg::CFG_FALLBACK_LEVEL: fallback_q <= cfg_data_i[bva_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [1:0]                  mode_q;
  logic [COORD_BITS-1:0]       x_q, y_q, z_q;
  logic [bva_pkg::IDX_W-1:0]   ei_q;
  logic                        ld_q;
  logic [bva_pkg::LEVEL_W-1:0] lv_q;

  // index arithmetic
  logic [COORD_BITS-1:0]       bx_q, bz_q;
  logic [COORD_BITS+CW-1:0]    byn_q;
  logic [2*CW-1:0]             nxny_q;
  logic [PROD_W-1:0]           bz_prod;
  logic [LIN_W-1:0]            lin_q;
  logic                        oor_q, oor_d;

  logic [AW-1:0]               clr_addr_q;
  logic [AW-1:0]               addr;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  bva_pkg::entry_t             ram_wdata, rd_entry, new_entry;
  logic [EW-1:0]               rd_raw;
  logic                        wr_ok;

  logic                        in_fire, done_fire;

  // output register
  logic                        out_valid_q;
  logic [bva_pkg::IDX_W-1:0]   brick_index_q, brick_index_d;
  logic [bva_pkg::OFF_W-1:0]   voxel_offset_q, voxel_offset_d;
  logic [bva_pkg::LEVEL_W-1:0] level_q, level_d;
  logic                        from_fallback_q, from_fallback_d;
  logic                        out_of_range_q;
  logic                        used_before_q, used_before_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign done_fire  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == LastAddr) state_d = ST_IDLE;
      ST_IDLE:  if (in_fire) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_DONE;
      ST_DONE:  if (done_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      x_q    <= x_coord_i;
      y_q    <= y_coord_i;
      z_q    <= z_coord_i;
      ei_q   <= entry_index_i;
      ld_q   <= entry_loaded_i;
      lv_q   <= entry_level_i;
    end
    if (state_q == ST_MUL) begin
      bx_q   <= x_q >> brick_shift_q;
      bz_q   <= z_q >> brick_shift_q;
      byn_q  <= (y_q >> brick_shift_q) * nx_q;
      nxny_q <= nx_q * ny_q;
    end
    if (state_q == ST_SUM) begin
      lin_q <= LIN_W'(bx_q) + LIN_W'(byn_q) + LIN_W'(bz_prod);
    end
    if (state_q == ST_ADDR) begin
      oor_q <= oor_d;
    end
    if (done_fire) begin
      brick_index_q   <= brick_index_d;
      voxel_offset_q  <= voxel_offset_d;
      level_q         <= level_d;
      from_fallback_q <= from_fallback_d;
      out_of_range_q  <= oor_q;
      used_before_q   <= used_before_d;
    end
  end

  assign bz_prod = bz_q * nxny_q;

  // table address and range check
  always_comb begin
    addr  = AW'(ei_q);
    oor_d = 1'b0;
    case (mode_q)
      bva_pkg::MODE_LOOKUP: begin
        addr  = lin_q[AW-1:0];
        oor_d = (lin_q >= MaxLin);
      end
      bva_pkg::MODE_WRITE,
      bva_pkg::MODE_READ_CLEAR: oor_d = ({5'b0, ei_q} >= MaxEi);
      default: oor_d = 1'b0;
    endcase
  end

  bva_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BRICKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr),
    .rdata_o(rd_raw)
  );

  assign rd_entry = bva_pkg::entry_t'(rd_raw);

  // read-modify-write of the entry and result assembly
  logic [COORD_BITS-1:0]       bmask;
  logic [bva_pkg::LEVEL_W-1:0] lvl;
  logic [COORD_BITS-1:0]       sx, sy, sz;

  always_comb begin
    bmask           = ~({COORD_BITS{1'b1}} << brick_shift_q);
    new_entry       = rd_entry;
    wr_ok           = 1'b0;
    brick_index_d   = '0;
    lvl             = fallback_q;
    from_fallback_d = 1'b0;
    used_before_d   = 1'b0;
    case (mode_q)
      bva_pkg::MODE_LOOKUP: begin
        brick_index_d   = lin_q[bva_pkg::IDX_W-1:0];
        from_fallback_d = 1'b1;
        wr_ok           = !oor_q;
        new_entry.used  = 1'b1;
        if (!oor_q && rd_entry.loaded) begin
          lvl             = rd_entry.level;
          from_fallback_d = 1'b0;
        end
      end
      bva_pkg::MODE_WRITE: begin
        brick_index_d    = ei_q;
        wr_ok            = !oor_q;
        new_entry.loaded = ld_q;
        new_entry.level  = lv_q;
      end
      bva_pkg::MODE_READ_CLEAR: begin
        brick_index_d  = ei_q;
        wr_ok          = !oor_q;
        used_before_d  = !oor_q && rd_entry.used;
        new_entry.used = 1'b0;
      end
      default: wr_ok = 1'b0;
    endcase
    sx = (x_q & bmask) >> lvl;
    sy = (y_q & bmask) >> lvl;
    sz = (z_q & bmask) >> lvl;
    if (mode_q == bva_pkg::MODE_LOOKUP) begin
      voxel_offset_d = bva_pkg::morton3(sx[bva_pkg::MORTON_IN_W-1:0],
                                        sy[bva_pkg::MORTON_IN_W-1:0],
                                        sz[bva_pkg::MORTON_IN_W-1:0]);
      level_d        = lvl;
    end else begin
      voxel_offset_d = '0;
      level_d        = '0;
    end
  end

  // clearing pass after reset shares the write port
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = done_fire && wr_ok;
      ram_waddr = addr;
      ram_wdata = new_entry;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign brick_index_o   = brick_index_q;
  assign voxel_offset_o  = voxel_offset_q;
  assign level_o         = level_q;
  assign from_fallback_o = from_fallback_q;
  assign out_of_range_o  = out_of_range_q;
  assign used_before_o   = used_before_q;

endmodule
`default_nettype wire

>>> test/tb_bricked_volume_voxel_address.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bricked_volume_voxel_address
// Self-checking bench for the voxel to brick address block. A directed table
// covers reset state, field extremes, every mode and the corner cases. Random
// phases under several brick geometries follow. Every result is compared,
// field by field, against a local model of the brick table and the address
// math or a directed row's fixed value. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_bricked_volume_voxel_address;
  import bva_pkg::*;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned PIPE_SLACK  = 8;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        z;
    logic [IDX_W-1:0]   entry;
    logic               loaded;
    logic [LEVEL_W-1:0] level;
  } voxel_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   brick_index;
    logic [OFF_W-1:0]   voxel_offset;
    logic [LEVEL_W-1:0] level;
    logic               from_fallback;
    logic               out_of_range;
    logic               used_before;
  } brick_addr_t;

  typedef struct packed {
    logic                  is_reg;
    cfg_idx_e              reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    voxel_item_t           item;
    logic                  fixed;
    brick_addr_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_e              cfg_index = CFG_BRICK_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  voxel_item_t in_item = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IDX_W-1:0]   brick_index;
  logic [OFF_W-1:0]   voxel_offset;
  logic [LEVEL_W-1:0] level;
  logic               from_fallback;
  logic               out_of_range;
  logic               used_before;

  // model copy of the configuration and the brick table
  logic [SHIFT_W-1:0] cur_shift    = 4'd6;
  logic [COUNT_W-1:0] cur_nx       = 13'd16;
  logic [COUNT_W-1:0] cur_ny       = 13'd16;
  logic [LEVEL_W-1:0] cur_fallback = 2'd3;
  bit                 loaded_mark[TABLE_DEPTH];
  bit [1:0]           level_mark[TABLE_DEPTH];
  bit                 used_mark[TABLE_DEPTH];

  brick_addr_t pending_addrs[$];
  stim_row_t   stim_rows[$];
  int unsigned mismatches = 0;
  bit          hold_request = 1'b0;

  bricked_volume_voxel_address i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (in_item.mode),
    .x_coord_i      (in_item.x),
    .y_coord_i      (in_item.y),
    .z_coord_i      (in_item.z),
    .entry_index_i  (in_item.entry),
    .entry_loaded_i (in_item.loaded),
    .entry_level_i  (in_item.level),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .brick_index_o  (brick_index),
    .voxel_offset_o (voxel_offset),
    .level_o        (level),
    .from_fallback_o(from_fallback),
    .out_of_range_o (out_of_range),
    .used_before_o  (used_before)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [47:0] interleave3(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c);
    logic [47:0] r;
    int          i;
    r = '0;
    for (i = 0; i < 16; i++) begin
      r[3*i]     = a[i];
      r[3*i + 1] = b[i];
      r[3*i + 2] = c[i];
    end
    return r;
  endfunction

  // address math and brick table update for one item
  function automatic brick_addr_t translate_voxel(voxel_item_t it);
    brick_addr_t        r;
    logic [63:0]        lin;
    logic [15:0]        bmask;
    logic [LEVEL_W-1:0] lvl;
    logic [47:0]        m;
    r = '0;
    case (it.mode)
      MODE_LOOKUP: begin
        lin = 64'(it.x >> cur_shift) + 64'(it.y >> cur_shift) * 64'(cur_nx)
            + 64'(it.z >> cur_shift) * 64'(cur_nx) * 64'(cur_ny);
        bmask = 16'((17'd1 << cur_shift) - 17'd1);
        lvl = cur_fallback;
        r.from_fallback = 1'b1;
        r.out_of_range = (lin >= TABLE_DEPTH);
        if (!r.out_of_range) begin
          used_mark[lin[IDX_W-1:0]] = 1'b1;
          if (loaded_mark[lin[IDX_W-1:0]]) begin
            lvl = level_mark[lin[IDX_W-1:0]];
            r.from_fallback = 1'b0;
          end
        end
        m = interleave3((it.x & bmask) >> lvl, (it.y & bmask) >> lvl, (it.z & bmask) >> lvl);
        r.brick_index = lin[IDX_W-1:0];
        r.voxel_offset = m[OFF_W-1:0];
        r.level = lvl;
      end
      // a 12 bit entry index always lies inside the table
      MODE_WRITE: begin
        r.brick_index = it.entry;
        loaded_mark[it.entry] = it.loaded;
        level_mark[it.entry] = it.level;
      end
      MODE_READ_CLEAR: begin
        r.brick_index = it.entry;
        r.used_before = used_mark[it.entry];
        used_mark[it.entry] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] mode, int unsigned x, int unsigned y,
                                         int unsigned z, int unsigned entry,
                                         int unsigned loaded, int unsigned lvl);
    stim_row_t r;
    r = '0;
    r.item.mode = mode;
    r.item.x = 16'(x);
    r.item.y = 16'(y);
    r.item.z = 16'(z);
    r.item.entry = IDX_W'(entry);
    r.item.loaded = 1'(loaded);
    r.item.level = LEVEL_W'(lvl);
    return r;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_e idx, int unsigned value);
    stim_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_index = idx;
    r.reg_value = CFG_DATA_W'(value);
    return r;
  endfunction

  function automatic brick_addr_t res(int unsigned idx, int unsigned off, int unsigned lvl,
                                      int unsigned fb, int unsigned oor, int unsigned ub);
    brick_addr_t r;
    r.brick_index = IDX_W'(idx);
    r.voxel_offset = OFF_W'(off);
    r.level = LEVEL_W'(lvl);
    r.from_fallback = 1'(fb);
    r.out_of_range = 1'(oor);
    r.used_before = 1'(ub);
    return r;
  endfunction

  function automatic stim_row_t checked(stim_row_t row, brick_addr_t want);
    row.fixed = 1'b1;
    row.want = want;
    return row;
  endfunction

  // append one row to the end of the stimulus table
  function automatic void add_row(stim_row_t row);
    stim_rows = {stim_rows, row};
  endfunction

  function automatic int unsigned draw_gap(int unsigned n);
    return (n % 64 < 16) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic voxel_item_t draw_item();
    voxel_item_t it;
    int unsigned pick;
    int unsigned hot;
    int unsigned bx;
    int unsigned by;
    int unsigned bz;
    logic [15:0] low_mask;
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.z = 16'($urandom);
    it.entry = IDX_W'($urandom);
    it.loaded = 1'($urandom);
    it.level = LEVEL_W'($urandom);
    hot = $urandom_range(0, 47);
    low_mask = 16'((17'd1 << cur_shift) - 17'd1);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.mode = MODE_LOOKUP;
      // most lookups land on a small hot set of bricks so that writes and lookups meet
      if ($urandom_range(0, 9) < 7) begin
        bx = hot % cur_nx;
        by = (hot / cur_nx) % cur_ny;
        bz = hot / (cur_nx * cur_ny);
        it.x = 16'(bx << cur_shift) | (it.x & low_mask);
        it.y = 16'(by << cur_shift) | (it.y & low_mask);
        it.z = 16'(bz << cur_shift) | (it.z & low_mask);
      end
    end else if (pick < 80) begin
      it.mode = MODE_WRITE;
      if ($urandom_range(0, 9) < 7) it.entry = IDX_W'(hot);
    end else if (pick < 95) begin
      it.mode = MODE_READ_CLEAR;
      if ($urandom_range(0, 9) < 7) it.entry = IDX_W'(hot);
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(voxel_item_t it, logic fixed, brick_addr_t want, int unsigned gap);
    brick_addr_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = translate_voxel(it);
    if (fixed) predicted = want;
    pending_addrs = {pending_addrs, predicted};
  endtask

  task automatic program_reg(cfg_idx_e idx, int unsigned value);
    wait_drained();
    repeat (PIPE_SLACK) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BRICK_SHIFT:    cur_shift = SHIFT_W'(value);
      CFG_BRICKS_ALONG_X: cur_nx = COUNT_W'(value);
      CFG_BRICKS_ALONG_Y: cur_ny = COUNT_W'(value);
      CFG_FALLBACK_LEVEL: cur_fallback = LEVEL_W'(value);
      default: ;
    endcase
  endtask

  task automatic run_phase(int unsigned shift, int unsigned nx, int unsigned ny,
                           int unsigned fb, int unsigned count, bit pressure);
    int unsigned n;
    program_reg(CFG_BRICK_SHIFT, shift);
    program_reg(CFG_BRICKS_ALONG_X, nx);
    program_reg(CFG_BRICKS_ALONG_Y, ny);
    program_reg(CFG_FALLBACK_LEVEL, fb);
    for (n = 0; n < count; n++) begin
      if (pressure && n == 40) hold_request = 1'b1;
      if (pressure && n == 120) wait_drained();
      send_item(draw_item(), 1'b0, '0, draw_gap(n));
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    add_row(checked(item_row(MODE_LOOKUP, 0, 0, 0, 0, 0, 0), res(0, 0, 3, 1, 0, 0)));
    // the lookup above set the used mark of brick 0
    add_row(checked(item_row(MODE_READ_CLEAR, 0, 0, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 1)));
    add_row(checked(item_row(MODE_READ_CLEAR, 0, 0, 0, 0, 0, 0), res(0, 0, 0, 0, 0, 0)));
    add_row(checked(item_row(MODE_WRITE, 0, 0, 0, 5, 1, 0), res(5, 0, 0, 0, 0, 0)));
    add_row(checked(item_row(MODE_LOOKUP, 383, 63, 63, 0, 0, 0),
                    res(5, 'h3FFFF, 0, 0, 0, 0)));
    // out of range lookup, must leave no used mark behind
    add_row(item_row(MODE_LOOKUP, 65535, 65535, 65535, 4095, 1, 3));
    add_row(checked(item_row(MODE_READ_CLEAR, 0, 0, 0, 751, 0, 0), res(751, 0, 0, 0, 0, 0)));
    add_row(checked(item_row(MODE_UNUSED, 65535, 65535, 65535, 4095, 1, 3),
                    res(0, 0, 0, 0, 0, 0)));
    add_row(checked(item_row(MODE_WRITE, 0, 0, 0, 4095, 1, 3), res(4095, 0, 0, 0, 0, 0)));
    add_row(checked(item_row(MODE_LOOKUP, 1023, 1023, 1023, 0, 0, 0),
                    res(4095, 511, 3, 0, 0, 0)));
    // x past the grid wraps into the next row of bricks
    add_row(item_row(MODE_LOOKUP, 1024, 0, 0, 0, 0, 0));
    add_row(checked(item_row(MODE_WRITE, 0, 0, 0, 16, 0, 2), res(16, 0, 0, 0, 0, 0)));
    // a write keeps the used mark
    add_row(checked(item_row(MODE_READ_CLEAR, 0, 0, 0, 16, 0, 0), res(16, 0, 0, 0, 0, 1)));
    add_row(item_row(MODE_WRITE, 0, 0, 0, 7, 1, 2));
    add_row(item_row(MODE_LOOKUP, 490, 21, 63, 0, 0, 0));
    add_row(reg_row(CFG_BRICK_SHIFT, 2));
    add_row(reg_row(CFG_BRICKS_ALONG_X, 5));
    add_row(reg_row(CFG_BRICKS_ALONG_Y, 7));
    add_row(reg_row(CFG_FALLBACK_LEVEL, 1));
    add_row(checked(item_row(MODE_WRITE, 0, 0, 0, 3, 1, 3), res(3, 0, 0, 0, 0, 0)));
    // level above the brick shift scales the offset to zero
    add_row(checked(item_row(MODE_LOOKUP, 15, 3, 3, 0, 0, 0), res(3, 0, 3, 0, 0, 0)));
    add_row(checked(item_row(MODE_LOOKUP, 0, 0, 0, 0, 0, 0), res(0, 0, 1, 1, 0, 0)));
    add_row(reg_row(CFG_BRICK_SHIFT, 8));
    add_row(reg_row(CFG_BRICKS_ALONG_X, 4096));
    add_row(reg_row(CFG_BRICKS_ALONG_Y, 4096));
    add_row(reg_row(CFG_FALLBACK_LEVEL, 0));
    // widest brick fills all 24 offset bits
    add_row(checked(item_row(MODE_LOOKUP, 255, 255, 255, 0, 0, 0),
                    res(0, 'hFFFFFF, 0, 1, 0, 0)));
    add_row(item_row(MODE_LOOKUP, 65535, 65535, 65535, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < stim_rows.size(); k++) begin
      if (stim_rows[k].is_reg)
        program_reg(stim_rows[k].reg_index, stim_rows[k].reg_value);
      else
        send_item(stim_rows[k].item, stim_rows[k].fixed, stim_rows[k].want, draw_gap(k));
    end

    run_phase(0, 1, 1, 0, 220, 1'b0);
    run_phase(8, 4096, 4096, 3, 220, 1'b0);
    run_phase(2, 5, 7, 1, 220, 1'b1);
    run_phase(4, 64, 64, 2, 220, 1'b0);
    run_phase(1, 4096, 1, 0, 220, 1'b0);
    run_phase(3, 1, 4096, 2, 220, 1'b0);
    run_phase(7, 13, 9, 3, 210, 1'b0);

    wait_drained();
    repeat (PIPE_SLACK) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_bricked_volume_voxel_address OK");
    end else begin
      $display("tb_bricked_volume_voxel_address NOT OK");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    brick_addr_t want;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        // long hold so the block backs up and stalls its input
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else if (taken % 50 < 12) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
      if (pending_addrs.size() == 0) begin
        report_mismatch("result with nothing expected", brick_index, 0);
      end else begin
        want = pending_addrs.pop_front();
        if (brick_index !== want.brick_index)
          report_mismatch("brick_index", brick_index, want.brick_index);
        if (voxel_offset !== want.voxel_offset)
          report_mismatch("voxel_offset", voxel_offset, want.voxel_offset);
        if (level !== want.level)
          report_mismatch("level", level, want.level);
        if (from_fallback !== want.from_fallback)
          report_mismatch("from_fallback", from_fallback, want.from_fallback);
        if (out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", out_of_range, want.out_of_range);
        if (used_before !== want.used_before)
          report_mismatch("used_before", used_before, want.used_before);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_bricked_volume_voxel_address NOT OK");
    $finish;
  end

endmodule

>>> files.f
design/bva_pkg.sv
design/bva_ram.sv
design/bricked_volume_voxel_address.sv
test/tb_bricked_volume_voxel_address.sv
